// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define JPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// implication after a fixed number of cycles
`define JPC_ASSERT_DLY(lbl, clk, rst_n, ante, n, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error("%m: check failed");

`endif

// ===== hw/rtl/jpc_pkg.sv =====
// ---------------------------------------------------------------------------
// jpc_pkg
// Types, constants and the CORDIC step table of the position conditioner.
// ---------------------------------------------------------------------------
`default_nettype none

package jpc_pkg;

    localparam int CORDIC_ITERS = 30;
    localparam int PRESCALE     = 28;
    localparam int ACC_FRAC     = 24;
    localparam int Z_W          = 34;
    localparam int Q_W          = 7;
    localparam int PCT_MAX      = 100;
    localparam int CFG_IDX_W    = 3;

    localparam int DEG_45  = 45;
    localparam int DEG_90  = 90;
    localparam int DEG_135 = 135;
    localparam int DEG_180 = 180;
    localparam int DEG_225 = 225;
    localparam int DEG_315 = 315;
    localparam int DEG_360 = 360;

    localparam logic [Z_W-1:0] DEG_PER_RAD_Q24 = 34'd961263669;

    localparam logic [Z_W-1:0] STEP_TABLE [10] = '{
        34'd754974720, 34'd445687602, 34'd235489088, 34'd119537938, 34'd60000934,
        34'd30029717,  34'd15018523,  34'd7509720,   34'd3754917,   34'd1877466
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_CENTER,
        REG_Y_CENTER,
        REG_X_HIGH,
        REG_X_LOW,
        REG_Y_HIGH,
        REG_Y_LOW,
        REG_DEAD_BAND
    } t_reg_idx;

    typedef enum logic [2:0] {
        PK_ZERO,
        PK_RIGHT_ANGLE,
        PK_DIAGONAL,
        PK_OCTANT,
        PK_MIRROR
    } t_phi_kind;

    typedef enum logic [2:0] {
        DIR_RIGHT,
        DIR_UP,
        DIR_LEFT,
        DIR_DOWN,
        DIR_NEUTRAL
    } t_dir;

    typedef struct packed {
        logic           neg;
        logic           zero;
        logic           sat;
        logic [Q_W-1:0] quo;
    } t_axis;

    typedef struct packed {
        logic      valid;
        logic      neutral;
        logic      x_neg;
        logic      y_neg;
        t_phi_kind kind;
        t_axis     ax_x;
        t_axis     ax_y;
    } t_ctl;

    function automatic logic [Z_W-1:0] step_deg(input int idx);
        logic [Z_W:0] sum;
        if (idx < 10) begin
            return STEP_TABLE[idx];
        end
        sum = {1'b0, DEG_PER_RAD_Q24} + ((Z_W+1)'(1) << (idx - 1));
        return Z_W'(sum >> idx);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/jpc_front.sv =====
// ---------------------------------------------------------------------------
// jpc_front
// Calibration registers, offsets, spans, dead band and CORDIC operand setup.
// ---------------------------------------------------------------------------
`default_nettype none

module jpc_front import jpc_pkg::*; #(
    parameter int SAMPLE_BITS = 8
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic [SAMPLE_BITS-1:0]             i_x_sample,
    input  wire logic [SAMPLE_BITS-1:0]             i_y_sample,
    input  wire logic                               i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]               i_cfg_idx,
    input  wire logic [SAMPLE_BITS-1:0]             i_cfg_data,
    output t_ctl                                    o_ctl,
    output logic [SAMPLE_BITS+Q_W-1:0]              o_xr,
    output logic [SAMPLE_BITS+Q_W-1:0]              o_xd,
    output logic [SAMPLE_BITS+Q_W-1:0]              o_yr,
    output logic [SAMPLE_BITS+Q_W-1:0]              o_yd,
    output logic signed [SAMPLE_BITS+PRESCALE+2:0]  o_cx,
    output logic signed [SAMPLE_BITS+PRESCALE+2:0]  o_cy
);

    localparam int S  = SAMPLE_BITS;
    localparam int RW = SAMPLE_BITS + Q_W;
    localparam int CW = SAMPLE_BITS + PRESCALE + 3;

    logic [S-1:0] r_x_center, r_y_center, r_x_high, r_x_low, r_y_high, r_y_low;
    logic [6:0]   r_dead_band;

    t_ctl                 r_ctl, n_ctl;
    logic [RW-1:0]        r_xr, n_xr, r_xd, n_xd, r_yr, n_yr, r_yd, n_yd;
    logic signed [CW-1:0] r_cx, n_cx, r_cy, n_cy;

    logic [S-1:0] mx, my, op_a, op_b;
    logic         xneg, yneg;
    t_axis        axx, axy;

    function automatic void prep(
        input  logic [S-1:0]  smp,
        input  logic [S-1:0]  c,
        input  logic [S-1:0]  hi,
        input  logic [S-1:0]  lo,
        output logic [S-1:0]  mag,
        output logic          dneg,
        output t_axis         ax,
        output logic [RW-1:0] rem,
        output logic [RW-1:0] dv
    );
        logic signed [S:0] d, up, dn, sp;
        logic [S:0]        spm;
        d    = $signed({1'b0, smp}) - $signed({1'b0, c});
        up   = $signed({1'b0, hi}) - $signed({1'b0, c});
        dn   = $signed({1'b0, c}) - $signed({1'b0, lo});
        sp   = (d > 0) ? up : dn;
        mag  = d[S] ? S'(-d) : S'(d);
        spm  = sp[S] ? (S+1)'(-sp) : (S+1)'(sp);
        dv   = RW'(spm);
        rem  = RW'(mag) * RW'(PCT_MAX);
        dneg = d[S];
        ax.neg  = d[S] ^ sp[S];
        ax.zero = (d == '0);
        ax.sat  = (rem >= (dv << Q_W));
        ax.quo  = '0;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_center  <= S'(128);
            r_y_center  <= S'(128);
            r_x_high    <= S'(255);
            r_x_low     <= '0;
            r_y_high    <= S'(255);
            r_y_low     <= '0;
            r_dead_band <= 7'd10;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_X_CENTER:  r_x_center  <= i_cfg_data;
                REG_Y_CENTER:  r_y_center  <= i_cfg_data;
                REG_X_HIGH:    r_x_high    <= i_cfg_data;
                REG_X_LOW:     r_x_low     <= i_cfg_data;
                REG_Y_HIGH:    r_y_high    <= i_cfg_data;
                REG_Y_LOW:     r_y_low     <= i_cfg_data;
                REG_DEAD_BAND: r_dead_band <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prep(i_x_sample, r_x_center, r_x_high, r_x_low, mx, xneg, axx, n_xr, n_xd);
        prep(i_y_sample, r_y_center, r_y_high, r_y_low, my, yneg, axy, n_yr, n_yd);

        n_ctl.valid   = i_start;
        n_ctl.neutral = (mx < S'(r_dead_band)) && (my < S'(r_dead_band));
        n_ctl.x_neg   = xneg;
        n_ctl.y_neg   = yneg;
        n_ctl.ax_x    = axx;
        n_ctl.ax_y    = axy;

        if (my == '0) begin
            n_ctl.kind = PK_ZERO;
        end else if (mx == '0) begin
            n_ctl.kind = PK_RIGHT_ANGLE;
        end else if (mx == my) begin
            n_ctl.kind = PK_DIAGONAL;
        end else if (my < mx) begin
            n_ctl.kind = PK_OCTANT;
        end else begin
            n_ctl.kind = PK_MIRROR;
        end

        op_a = (n_ctl.kind == PK_MIRROR) ? my : mx;
        op_b = (n_ctl.kind == PK_MIRROR) ? mx : my;
        n_cx = $signed(CW'(op_a) << PRESCALE);
        n_cy = $signed(CW'(op_b) << PRESCALE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xr <= n_xr;
        r_xd <= n_xd;
        r_yr <= n_yr;
        r_yd <= n_yd;
        r_cx <= n_cx;
        r_cy <= n_cy;
    end

    assign o_ctl = r_ctl;
    assign o_xr  = r_xr;
    assign o_xd  = r_xd;
    assign o_yr  = r_yr;
    assign o_yd  = r_yd;
    assign o_cx  = r_cx;
    assign o_cy  = r_cy;

endmodule

`default_nettype wire

// ===== hw/rtl/jpc_stage.sv =====
// ---------------------------------------------------------------------------
// jpc_stage
// One pipeline stage: one CORDIC vectoring step, plus one quotient bit per axis when IDX < Q_W.
// ---------------------------------------------------------------------------
`default_nettype none

module jpc_stage import jpc_pkg::*; #(
    parameter int SAMPLE_BITS = 8,
    parameter int IDX         = 0
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire t_ctl                               i_ctl,
    input  wire logic [SAMPLE_BITS+Q_W-1:0]         i_xr,
    input  wire logic [SAMPLE_BITS+Q_W-1:0]         i_xd,
    input  wire logic [SAMPLE_BITS+Q_W-1:0]         i_yr,
    input  wire logic [SAMPLE_BITS+Q_W-1:0]         i_yd,
    input  wire logic signed [SAMPLE_BITS+PRESCALE+2:0] i_cx,
    input  wire logic signed [SAMPLE_BITS+PRESCALE+2:0] i_cy,
    input  wire logic signed [Z_W-1:0]              i_z,
    output t_ctl                                    o_ctl,
    output logic [SAMPLE_BITS+Q_W-1:0]              o_xr,
    output logic [SAMPLE_BITS+Q_W-1:0]              o_xd,
    output logic [SAMPLE_BITS+Q_W-1:0]              o_yr,
    output logic [SAMPLE_BITS+Q_W-1:0]              o_yd,
    output logic signed [SAMPLE_BITS+PRESCALE+2:0]  o_cx,
    output logic signed [SAMPLE_BITS+PRESCALE+2:0]  o_cy,
    output logic signed [Z_W-1:0]                   o_z
);

    localparam int RW = SAMPLE_BITS + Q_W;
    localparam int CW = SAMPLE_BITS + PRESCALE + 3;
    localparam int K  = (IDX < Q_W) ? (Q_W - 1 - IDX) : 0;
    localparam logic signed [Z_W-1:0] STEP = $signed(step_deg(IDX));

    t_ctl                 r_ctl, n_ctl;
    logic [RW-1:0]        r_xr, n_xr, r_yr, n_yr, r_xd, r_yd;
    logic signed [CW-1:0] r_cx, n_cx, r_cy, n_cy, xs, ys;
    logic signed [Z_W-1:0] r_z, n_z;

    function automatic void dstep(
        input  t_axis         ai,
        input  logic [RW-1:0] r,
        input  logic [RW-1:0] d,
        output t_axis         ao,
        output logic [RW-1:0] ro
    );
        logic [RW-1:0] dsh;
        dsh = d << K;
        ao  = ai;
        ro  = r;
        if (r >= dsh) begin
            ro     = r - dsh;
            ao.quo[K] = 1'b1;
        end
    endfunction

    always_comb begin
        n_ctl = i_ctl;
        n_xr  = i_xr;
        n_yr  = i_yr;
        if (IDX < Q_W) begin
            dstep(i_ctl.ax_x, i_xr, i_xd, n_ctl.ax_x, n_xr);
            dstep(i_ctl.ax_y, i_yr, i_yd, n_ctl.ax_y, n_yr);
        end

        xs = i_cx >>> IDX;
        ys = i_cy >>> IDX;
        if (i_cy > 0) begin
            n_cx = i_cx + ys;
            n_cy = i_cy - xs;
            n_z  = i_z + STEP;
        end else begin
            n_cx = i_cx - ys;
            n_cy = i_cy + xs;
            n_z  = i_z - STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xr <= n_xr;
        r_yr <= n_yr;
        r_xd <= i_xd;
        r_yd <= i_yd;
        r_cx <= n_cx;
        r_cy <= n_cy;
        r_z  <= n_z;
    end

    assign o_ctl = r_ctl;
    assign o_xr  = r_xr;
    assign o_xd  = r_xd;
    assign o_yr  = r_yr;
    assign o_yd  = r_yd;
    assign o_cx  = r_cx;
    assign o_cy  = r_cy;
    assign o_z   = r_z;

endmodule

`default_nettype wire

// ===== hw/rtl/jpc_back.sv =====
// ---------------------------------------------------------------------------
// jpc_back
// Angle rounding, quadrant mapping, percent saturation and direction.
// ---------------------------------------------------------------------------
`default_nettype none

module jpc_back import jpc_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_ctl                  i_ctl,
    input  wire logic signed [Z_W-1:0] i_z,
    output logic                       o_valid,
    output logic signed [7:0]          o_x_percent,
    output logic signed [7:0]          o_y_percent,
    output logic [8:0]                 o_angle_deg,
    output logic                       o_is_neutral,
    output logic [2:0]                 o_direction
);

    localparam int F  = ANGLE_FRAC_BITS;
    localparam int SH = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int PW = ANGLE_FRAC_BITS + 8;
    localparam logic [Z_W-1:0] HALF = Z_W'((64'd1 << SH) >> 1);

    t_ctl                r_b1_ctl;
    logic [PW-1:0]       r_mag, n_mag, phi, oct;
    logic [Z_W-1:0]      zc;
    logic signed [7:0]   r_xp, n_xp, r_yp, n_yp;

    logic                r_valid;
    logic signed [7:0]   r_x_percent, r_y_percent;
    logic [8:0]          r_angle, n_angle;
    logic                r_neutral;
    t_dir                r_dir, n_dir;
    logic [7:0]          whole;

    function automatic logic signed [7:0] pct(input t_axis a);
        logic [Q_W-1:0] m;
        if (a.sat || (a.quo > Q_W'(PCT_MAX))) begin
            m = Q_W'(PCT_MAX);
        end else begin
            m = a.quo;
        end
        if (a.zero) begin
            m = '0;
        end
        return a.neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

    always_comb begin
        zc  = i_z[Z_W-1] ? '0 : $unsigned(i_z);
        oct = PW'((zc + HALF) >> SH);
        case (i_ctl.kind)
            PK_ZERO:        phi = '0;
            PK_RIGHT_ANGLE: phi = PW'(DEG_90) << F;
            PK_DIAGONAL:    phi = PW'(DEG_45) << F;
            PK_OCTANT:      phi = oct;
            PK_MIRROR:      phi = (PW'(DEG_90) << F) - oct;
            default:        phi = '0;
        endcase
        n_mag = i_ctl.x_neg ? (PW'(DEG_180) << F) - phi : phi;
        n_xp  = pct(i_ctl.ax_x);
        n_yp  = pct(i_ctl.ax_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_ctl <= '0;
        end else begin
            r_b1_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;
        r_xp  <= n_xp;
        r_yp  <= n_yp;
    end

    always_comb begin
        whole = 8'(r_mag >> F);
        if (r_b1_ctl.y_neg && (whole != '0)) begin
            n_angle = 9'(DEG_360) - 9'(whole);
        end else begin
            n_angle = 9'(whole);
        end
        if (n_angle <= 9'(DEG_45) || n_angle > 9'(DEG_315)) begin
            n_dir = DIR_RIGHT;
        end else if (n_angle <= 9'(DEG_135)) begin
            n_dir = DIR_UP;
        end else if (n_angle <= 9'(DEG_225)) begin
            n_dir = DIR_LEFT;
        end else begin
            n_dir = DIR_DOWN;
        end
        if (r_b1_ctl.neutral) begin
            n_angle = '0;
            n_dir   = DIR_NEUTRAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_b1_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x_percent <= r_xp;
        r_y_percent <= r_yp;
        r_angle     <= n_angle;
        r_neutral   <= r_b1_ctl.neutral;
        r_dir       <= n_dir;
    end

    assign o_valid      = r_valid;
    assign o_x_percent  = r_x_percent;
    assign o_y_percent  = r_y_percent;
    assign o_angle_deg  = r_angle;
    assign o_is_neutral = r_neutral;
    assign o_direction  = r_dir;

endmodule

`default_nettype wire

// ===== hw/rtl/joystick_position_conditioner.sv =====
// ---------------------------------------------------------------------------
// joystick_position_conditioner
// Calibrated percent deflection, angle and direction of an x/y stick sample.
//
//   channel  signals                                   transaction
//   input    i_start, o_busy, i_x_sample, i_y_sample   i_start & !o_busy
//   result   o_valid, o_*_percent, o_angle_deg, ...    o_valid, one cycle
//   config   i_cfg_we, i_cfg_idx, i_cfg_data           i_cfg_we
//
// One sample pair per cycle while o_busy is low; each result passes through
// one setup stage, 30 CORDIC stages (the percent division shares the first
// seven) and two output stages.
// o_busy is high only during reset; reset flushes the pipeline.
// The receiver cannot stall: o_valid pulses for one cycle per result.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module joystick_position_conditioner import jpc_pkg::*; #(
    parameter int SAMPLE_BITS     = 8,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    output logic                        o_busy,
    input  wire logic [SAMPLE_BITS-1:0] i_x_sample,
    input  wire logic [SAMPLE_BITS-1:0] i_y_sample,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [SAMPLE_BITS-1:0] i_cfg_data,
    output logic                        o_valid,
    output logic signed [7:0]           o_x_percent,
    output logic signed [7:0]           o_y_percent,
    output logic [8:0]                  o_angle_deg,
    output logic                        o_is_neutral,
    output logic [2:0]                  o_direction
);

    localparam int RW  = SAMPLE_BITS + Q_W;
    localparam int CW  = SAMPLE_BITS + PRESCALE + 3;
    localparam int LAT = CORDIC_ITERS + 3;

    t_ctl                  s_ctl [0:CORDIC_ITERS];
    logic [RW-1:0]         s_xr  [0:CORDIC_ITERS];
    logic [RW-1:0]         s_xd  [0:CORDIC_ITERS];
    logic [RW-1:0]         s_yr  [0:CORDIC_ITERS];
    logic [RW-1:0]         s_yd  [0:CORDIC_ITERS];
    logic signed [CW-1:0]  s_cx  [0:CORDIC_ITERS];
    logic signed [CW-1:0]  s_cy  [0:CORDIC_ITERS];
    logic signed [Z_W-1:0] s_z   [0:CORDIC_ITERS];

    assign o_busy = !i_rst_n;
    assign s_z[0] = '0;

    jpc_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_x_sample (i_x_sample),
        .i_y_sample (i_y_sample),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_ctl      (s_ctl[0]),
        .o_xr       (s_xr[0]),
        .o_xd       (s_xd[0]),
        .o_yr       (s_yr[0]),
        .o_yd       (s_yd[0]),
        .o_cx       (s_cx[0]),
        .o_cy       (s_cy[0])
    );

    for (genvar g = 0; g < CORDIC_ITERS; g++) begin : g_stage
        jpc_stage #(.SAMPLE_BITS(SAMPLE_BITS), .IDX(g)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (s_ctl[g]),
            .i_xr    (s_xr[g]),
            .i_xd    (s_xd[g]),
            .i_yr    (s_yr[g]),
            .i_yd    (s_yd[g]),
            .i_cx    (s_cx[g]),
            .i_cy    (s_cy[g]),
            .i_z     (s_z[g]),
            .o_ctl   (s_ctl[g+1]),
            .o_xr    (s_xr[g+1]),
            .o_xd    (s_xd[g+1]),
            .o_yr    (s_yr[g+1]),
            .o_yd    (s_yd[g+1]),
            .o_cx    (s_cx[g+1]),
            .o_cy    (s_cy[g+1]),
            .o_z     (s_z[g+1])
        );
    end

    jpc_back #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (s_ctl[CORDIC_ITERS]),
        .i_z          (s_z[CORDIC_ITERS]),
        .o_valid      (o_valid),
        .o_x_percent  (o_x_percent),
        .o_y_percent  (o_y_percent),
        .o_angle_deg  (o_angle_deg),
        .o_is_neutral (o_is_neutral),
        .o_direction  (o_direction)
    );

    `JPC_ASSERT_DLY(a_latency, i_clk, i_rst_n, i_start && !o_busy, LAT, o_valid)
    `JPC_ASSERT_IMP(a_neutral_out, i_clk, i_rst_n, o_valid && o_is_neutral, o_direction == DIR_NEUTRAL && o_angle_deg == '0)
    `JPC_ASSERT_IMP(a_moved_out, i_clk, i_rst_n, o_valid && !o_is_neutral, o_direction != DIR_NEUTRAL && o_angle_deg < 9'd360)
    `JPC_ASSERT_IMP(a_pct_range, i_clk, i_rst_n, o_valid, o_x_percent >= -8'sd100 && o_x_percent <= 8'sd100 && o_y_percent >= -8'sd100 && o_y_percent <= 8'sd100)

endmodule

`default_nettype wire
